// ----- hw/rtl/ilmct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilmct_pkg
// Shared codes and types for the interrupt latch/mask controller with its
// compare timer.
// ----------------------------------------------------------------------------
package ilmct_pkg;

   localparam int DataBits = 64;

   // command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_LINE  = 2'd3;

   // register select codes
   localparam logic [3:0] SEL_MASK0   = 4'd0;
   localparam logic [3:0] SEL_MASK1   = 4'd1;
   localparam logic [3:0] SEL_MASK2   = 4'd2;
   localparam logic [3:0] SEL_MASK3   = 4'd3;
   localparam logic [3:0] SEL_SET     = 4'd4;
   localparam logic [3:0] SEL_CLEAR   = 4'd5;
   localparam logic [3:0] SEL_STATUS  = 4'd6;
   localparam logic [3:0] SEL_MASKED  = 4'd7;
   localparam logic [3:0] SEL_COUNT   = 4'd8;
   localparam logic [3:0] SEL_COMPARE = 4'd9;

   // access part codes
   localparam logic [1:0] PART_FULL = 2'd0;
   localparam logic [1:0] PART_HIGH = 2'd1;
   localparam logic [1:0] PART_LOW  = 2'd2;

   typedef struct packed {
      logic [1:0]          command;
      logic [3:0]          reg_select;
      logic [1:0]          access_part;
      logic [DataBits-1:0] write_data;
      logic [5:0]          irq_vector;
      logic                irq_level;
   } req_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ilmct_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilmct_req_if
// Request channel: bus accesses, counter ticks and device line events.
// ----------------------------------------------------------------------------
interface ilmct_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [3:0]                    reg_select;
   logic [1:0]                    access_part;
   logic [ilmct_pkg::DataBits-1:0] write_data;
   logic [5:0]                    irq_vector;
   logic                          irq_level;

   modport source (
      output valid, command, reg_select, access_part, write_data, irq_vector,
             irq_level,
      input  ready
   );
   modport sink (
      input  valid, command, reg_select, access_part, write_data, irq_vector,
             irq_level,
      output ready
   );
endinterface
`default_nettype wire

// ----- hw/rtl/ilmct_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilmct_rsp_if
// Response channel: read data and aggregate interrupt level.
// ----------------------------------------------------------------------------
interface ilmct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ilmct_pkg::DataBits-1:0] read_data;
   logic                          irq_out;

   modport source (output valid, read_data, irq_out, input ready);
   modport sink (input valid, read_data, irq_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ilmct_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilmct_core
// Status, mask, count and compare registers. Works out the next state and
// the response for one transaction; state moves on when take is high.
// ----------------------------------------------------------------------------
module ilmct_core #(
   parameter int NUM_VECTORS  = 64,
   parameter int COUNT_BITS   = 48,
   parameter int TIMER_VECTOR = 50,
   parameter int NUM_MASKS    = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           take,
   input  wire ilmct_pkg::req_type             req,
   output logic     [ilmct_pkg::DataBits-1:0]  read_data,
   output logic                                irq_out
);

   localparam logic [NUM_VECTORS-1:0] VecOne = {{(NUM_VECTORS-1){1'b0}}, 1'b1};
   // out-of-range timer vector shifts out to nothing
   localparam logic [NUM_VECTORS-1:0] TimerBit = VecOne << TIMER_VECTOR;

   logic [NUM_VECTORS-1:0]          status_ff, status_in;
   logic [ilmct_pkg::DataBits-1:0]  mask_ff [NUM_MASKS];
   logic [ilmct_pkg::DataBits-1:0]  mask_in [NUM_MASKS];
   logic [COUNT_BITS-1:0]           count_ff, count_in;
   logic [ilmct_pkg::DataBits-1:0]  compare_ff, compare_in;
   logic [ilmct_pkg::DataBits-1:0]  rd_full;
   logic [ilmct_pkg::DataBits-1:0]  rd_mask;
   logic [COUNT_BITS-1:0]           cmp_cut;

   assign cmp_cut = compare_ff[COUNT_BITS-1:0];

   // mask read selection
   always_comb begin
      rd_mask = '0;
      for (int i = 0; i < NUM_MASKS; i++) begin
         if (req.reg_select == 4'(i)) begin
            rd_mask = mask_ff[i];
         end
      end
   end

   always_comb begin
      case (req.reg_select)
         ilmct_pkg::SEL_MASK0, ilmct_pkg::SEL_MASK1,
         ilmct_pkg::SEL_MASK2, ilmct_pkg::SEL_MASK3: rd_full = rd_mask;
         ilmct_pkg::SEL_SET, ilmct_pkg::SEL_CLEAR,
         ilmct_pkg::SEL_STATUS:  rd_full = ilmct_pkg::DataBits'(status_ff);
         ilmct_pkg::SEL_MASKED:
            rd_full = ilmct_pkg::DataBits'(status_ff) & mask_ff[0];
         ilmct_pkg::SEL_COUNT:   rd_full = ilmct_pkg::DataBits'(count_ff);
         ilmct_pkg::SEL_COMPARE: rd_full = compare_ff;
         default:                rd_full = '0;
      endcase
   end

   always_comb begin
      status_in  = status_ff;
      count_in   = count_ff;
      compare_in = compare_ff;
      for (int i = 0; i < NUM_MASKS; i++) begin
         mask_in[i] = mask_ff[i];
      end
      read_data = '0;

      case (req.command)
         ilmct_pkg::CMD_READ: begin
            case (req.access_part)
               ilmct_pkg::PART_HIGH: read_data = {32'd0, rd_full[63:32]};
               ilmct_pkg::PART_LOW:  read_data = {32'd0, rd_full[31:0]};
               default:              read_data = rd_full;
            endcase
         end
         ilmct_pkg::CMD_WRITE: begin
            for (int i = 0; i < NUM_MASKS; i++) begin
               if (req.reg_select == 4'(i)) begin
                  mask_in[i] = req.write_data;
               end
            end
            case (req.reg_select)
               ilmct_pkg::SEL_SET:
                  status_in = status_ff | req.write_data[NUM_VECTORS-1:0];
               ilmct_pkg::SEL_CLEAR, ilmct_pkg::SEL_STATUS:
                  status_in = status_ff & ~req.write_data[NUM_VECTORS-1:0];
               ilmct_pkg::SEL_COMPARE:
                  compare_in = req.write_data;
               default: ;
            endcase
         end
         ilmct_pkg::CMD_TICK: begin
            count_in = count_ff + 1'b1;
            // compare of zero (after truncation) keeps the timer off
            if (cmp_cut != '0 && count_in == cmp_cut) begin
               status_in = status_ff | TimerBit;
            end
         end
         default: begin
            // line numbers at or beyond the vector count shift out
            if (req.irq_level) begin
               status_in = status_ff | (VecOne << req.irq_vector);
            end
         end
      endcase

      irq_out = |(status_in & mask_in[0][NUM_VECTORS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= '0;
         count_ff   <= '0;
         compare_ff <= '0;
         for (int i = 0; i < NUM_MASKS; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (take) begin
         status_ff  <= status_in;
         count_ff   <= count_in;
         compare_ff <= compare_in;
         for (int i = 0; i < NUM_MASKS; i++) begin
            mask_ff[i] <= mask_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/interrupt_latch_mask_compare_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_latch_mask_compare_timer
// Interrupt status/mask controller with a tick-driven compare timer.
// ----------------------------------------------------------------------------
// The response register is loaded when a request is accepted.
// Throughput: one transaction per cycle while responses are taken; the
//   register update and response are one level of logic on state registers.
// Request ready drops only while a response is held and not taken.
// Reset (synchronous) clears status, masks, count, compare and response valid.
module interrupt_latch_mask_compare_timer #(
   parameter int NUM_VECTORS  = 64,
   parameter int COUNT_BITS   = 48,
   parameter int TIMER_VECTOR = 50,
   parameter int NUM_MASKS    = 4
) (
   input wire logic    clock,
   input wire logic    reset,
   ilmct_req_if.sink   req_bus,
   ilmct_rsp_if.source rsp_bus
);

   ilmct_pkg::req_type             req;
   logic                           take;
   logic [ilmct_pkg::DataBits-1:0] core_rd;
   logic                           core_irq;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ilmct_pkg::DataBits-1:0] read_data_ff;
   logic                           irq_ff;

   assign req = '{
      command:     req_bus.command,
      reg_select:  req_bus.reg_select,
      access_part: req_bus.access_part,
      write_data:  req_bus.write_data,
      irq_vector:  req_bus.irq_vector,
      irq_level:   req_bus.irq_level
   };

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign take          = req_bus.valid && req_bus.ready;

   ilmct_core #(
      .NUM_VECTORS  (NUM_VECTORS),
      .COUNT_BITS   (COUNT_BITS),
      .TIMER_VECTOR (TIMER_VECTOR),
      .NUM_MASKS    (NUM_MASKS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req),
      .read_data (core_rd),
      .irq_out   (core_irq)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         read_data_ff <= core_rd;
         irq_ff       <= core_irq;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = read_data_ff;
   assign rsp_bus.irq_out   = irq_ff;

endmodule
`default_nettype wire
